@@ design/stable_priority_queue_macros.svh @@
// Assertion macros used by the priority queue top level.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/spq_pkg.sv @@
// Package for the priority queue: sizes, codes, entry and cell control types.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TREAT  = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_TREATED  = 3'd1;
  localparam logic [2:0] KIND_LISTED   = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;

  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  age;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;
    logic     is_tail;
  } cell_ctl_t;

  // Fit the entry count into the 5-bit result field.
  function automatic logic [4:0] count_field(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

endpackage

@@ design/stable_priority_queue.sv @@
// Top level of the stable priority queue: command decode, cell chain, result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   insert (priority_req, age, name_tag), treat (pop the head) or list.
//   Output channel (out_valid / out_stall) carries result transactions:
//   kind, the entry fields, the count after the step and a last flag.
//   Insert and treat put a result in the output register the cycle after the
//   command transaction and sustain one command per cycle while the receiver
//   does not stall; the work is one parallel shift of the cell chain.
//   List of n entries streams n results on consecutive cycles when the
//   receiver does not stall, head first, by rotating the occupied cells once
//   per result; the input stalls until the list ends and the chain is back
//   in order afterwards. A list on an empty queue and the unused command
//   code give no result. A full queue rejects inserts with a full error;
//   treating an empty queue gives an empty error.
//   Reset clears the count and the output valid; entry slots are not cleared.
//   While the receiver stalls, the result holds and the input stalls.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  priority_req,
  input  logic [7:0]  age,
  input  logic [15:0] name_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  priority_res,
  output logic [7:0]  age_res,
  output logic [15:0] name_tag_res,
  output logic [4:0]  count,
  output logic        last
);
  import spq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] remaining;

  entry_t    ent [DEPTH];
  logic      ge  [DEPTH];
  cell_ctl_t ctl [DEPTH];
  entry_t    new_entry;
  cell_op_t  op;

  logic in_accept;
  logic out_free;
  logic out_load;
  logic is_full;
  logic is_empty;

  assign new_entry = '{prio: priority_req, age: age, tag: name_tag};
  assign is_full   = (entry_count == CNT_W'(DEPTH));
  assign is_empty  = (entry_count == '0);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state == ST_LIST) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  // Load the result register on every insert or treat, and on each list step.
  assign out_load  = (state == ST_LIST) ? out_free
                   : (in_accept && (command == CMD_INSERT || command == CMD_TREAT));

  // Pick the chain operation for this cycle.
  always_comb begin
    op = OP_HOLD;
    if (state == ST_LIST) begin
      if (out_free) begin
        op = OP_ROTATE;
      end
    end else if (in_accept) begin
      if (command == CMD_INSERT && !is_full) begin
        op = OP_INSERT;
      end else if (command == CMD_TREAT && !is_empty) begin
        op = OP_POP;
      end
    end
  end

  // Row of cells; the head borrows the new entry as its left neighbor, the tail
  // sees itself on the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    entry_t right_e;

    assign ctl[i] = '{op: op,
                      occupied: (CNT_W'(i) < entry_count),
                      is_tail: (CNT_W'(i) == entry_count - CNT_W'(1))};

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = ent[i-1];
      assign left_g = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = ent[i];
    end else begin : g_mid
      assign right_e = ent[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .head_entry  (ent[0]),
      .entry       (ent[i]),
      .ge          (ge[i])
    );
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      remaining   <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Hold a stalled result, take a new one, or drop the one just accepted.
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (command)
              CMD_INSERT: begin
                priority_res <= '0;
                age_res      <= '0;
                name_tag_res <= '0;
                last         <= 1'b1;
                if (is_full) begin
                  kind  <= KIND_FULL;
                  count <= count_field(entry_count);
                end else begin
                  kind        <= KIND_INSERTED;
                  entry_count <= entry_count + CNT_W'(1);
                  count       <= count_field(entry_count + CNT_W'(1));
                end
              end
              CMD_TREAT: begin
                last      <= 1'b1;
                if (is_empty) begin
                  kind         <= KIND_EMPTY;
                  priority_res <= '0;
                  age_res      <= '0;
                  name_tag_res <= '0;
                  count        <= count_field(entry_count);
                end else begin
                  kind         <= KIND_TREATED;
                  priority_res <= ent[0].prio;
                  age_res      <= ent[0].age;
                  name_tag_res <= ent[0].tag;
                  entry_count  <= entry_count - CNT_W'(1);
                  count        <= count_field(entry_count - CNT_W'(1));
                end
              end
              CMD_LIST: begin
                if (!is_empty) begin
                  state     <= ST_LIST;
                  remaining <= entry_count;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LIST: begin
          // Emit the head and rotate; drop back to idle after the final entry.
          if (out_free) begin
            kind         <= KIND_LISTED;
            priority_res <= ent[0].prio;
            age_res      <= ent[0].age;
            name_tag_res <= ent[0].tag;
            count        <= count_field(entry_count);
            last         <= (remaining == CNT_W'(1));
            remaining    <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SPQ_ASSERT(a_count_bound, entry_count <= CNT_W'(DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_list_remaining, state != ST_LIST || (remaining != '0 && remaining <= entry_count), "list counter out of range")
  `SPQ_ASSERT(a_head_sorted, state == ST_LIST || entry_count < CNT_W'(2) || ent[0].prio >= ent[1].prio, "head entry out of order")
  `SPQ_ASSERT_NEXT(a_insert_count, in_accept && command == CMD_INSERT && !is_full, entry_count == $past(entry_count) + CNT_W'(1), "insert did not grow queue")
  `SPQ_ASSERT_NEXT(a_list_end, state == ST_LIST && out_free && remaining == CNT_W'(1), state == ST_IDLE && out_valid && last, "list did not end with last flag")

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   new_entry,
  input  spq_pkg::entry_t   left_entry,
  input  logic              left_ge,
  input  spq_pkg::entry_t   right_entry,
  input  spq_pkg::entry_t   head_entry,
  output spq_pkg::entry_t   entry,
  output logic              ge
);
  import spq_pkg::*;

  entry_t entry_next;

  // This slot stays ahead of the new entry when it is occupied and not lower.
  assign ge = ctl.occupied && (entry.prio >= new_entry.prio);

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      OP_INSERT: begin
        if (!ge) begin
          entry_next = left_ge ? new_entry : left_entry;
        end
      end
      OP_POP:    entry_next = right_entry;
      OP_ROTATE: entry_next = ctl.is_tail ? head_entry : right_entry;
      default:   entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
